FILE: rtl/affine_gap_global_alignment_defines.svh
// Assertion helpers shared by the alignment block.
`ifndef AFFINE_GAP_GLOBAL_ALIGNMENT_DEFINES_SVH
`define AFFINE_GAP_GLOBAL_ALIGNMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AGGA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("agga assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AGGA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("agga assertion failed");

`endif

FILE: rtl/agga_pkg.sv
package agga_pkg;

	localparam int MAX_LEN_DEF = 256;
	localparam int SW          = 32;
	localparam int OUT_W       = 18;

	typedef logic signed [SW-1:0] score_t;

	localparam score_t NEG_INF   = -score_t'(32'sd268435456);
	localparam score_t SCORE_MAX = score_t'(32'sd131071);
	localparam score_t SCORE_MIN = -score_t'(32'sd131072);

	typedef enum logic [1:0] {
		OP_LOAD_S = 2'd0,
		OP_LOAD_T = 2'd1,
		OP_FETCH  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_SCORE  = 2'd0,
		STAT_COLUMN = 2'd1,
		STAT_NONE   = 2'd2,
		STAT_OVER   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PTR_LEFT = 2'd0,
		PTR_UP   = 2'd1,
		PTR_DIAG = 2'd2
	} ptr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CRD,
		ST_CEX,
		ST_DONE,
		ST_FEX
	} state_t;

	localparam logic [7:0] CHAR_DASH = 8'h2d;
	localparam logic [7:0] CHAR_LA   = 8'h61;
	localparam logic [7:0] CHAR_LZ   = 8'h7a;
	localparam logic [7:0] CASE_OFS  = 8'h20;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= CHAR_LA && c <= CHAR_LZ) ? c - CASE_OFS : c;
	endfunction

	function automatic score_t similarity(input logic [7:0] a, input logic [7:0] b);
		if (upcase(a) == upcase(b))
			return (a != CHAR_DASH) ? score_t'(1) : score_t'(0);
		return -score_t'(1);
	endfunction

	function automatic logic signed [OUT_W-1:0] saturate(input score_t v);
		if (v > SCORE_MAX)
			return SCORE_MAX[OUT_W-1:0];
		if (v < SCORE_MIN)
			return SCORE_MIN[OUT_W-1:0];
		return v[OUT_W-1:0];
	endfunction

endpackage

FILE: rtl/agga_cell.sv
module agga_cell (
	input  agga_pkg::score_t diag,
	input  agga_pkg::score_t up,
	input  agga_pkg::score_t vgap,
	input  agga_pkg::score_t left,
	input  agga_pkg::score_t e_prev,
	input  agga_pkg::score_t go,
	input  agga_pkg::score_t ge,
	input  logic [7:0]       s_char,
	input  logic [7:0]       t_char,
	output agga_pkg::score_t v,
	output agga_pkg::score_t f,
	output agga_pkg::score_t e,
	output logic [1:0]       ptr
);
	import agga_pkg::*;

	score_t oe, g, f_a, f_b, e_a, e_b, fe;

	always_comb begin
		oe  = go + ge;
		g   = diag + similarity(s_char, t_char);
		f_a = vgap - ge;
		f_b = up - oe;
		f   = (f_a > f_b) ? f_a : f_b;
		e_a = e_prev - ge;
		e_b = left - oe;
		e   = (e_a > e_b) ? e_a : e_b;
		fe  = (f > e) ? f : e;
		v   = (g > fe) ? g : fe;
		// ties: diagonal, then left, then up
		if (v == g)
			ptr = PTR_DIAG;
		else if (v == e)
			ptr = PTR_LEFT;
		else
			ptr = PTR_UP;
	end

endmodule

FILE: rtl/affine_gap_global_alignment.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: symbol; tlast: last_symbol
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: score, columns; tlast: last_column
// cfg_*     in   cfg_we             cfg_index selects open (0) or extend (1) penalty
//
// A fetch reads the pointer and character memories in the accept cycle and forms the
// column in the next. The last T request runs the fill unless S overflowed or it is
// dropped: an init pass over the T columns, then per cell a read state (score/gap rows)
// and a compute and write-back state, over s_length*t_length cells, then a done state
// that posts the score. The read-modify-write of the row memories needs the read state.
// Reset is asynchronous, active low; it clears control state only, memories keep junk.
// s_tready drops during fill, fetch and while an unread result blocks the output register.
module affine_gap_global_alignment #(
	parameter int MAX_LEN = agga_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [17:0] score, [25:18] col_s_char, [26] col_s_gap,
	                               // [34:27] col_t_char, [35] col_t_gap, zero above
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import agga_pkg::*;

	localparam int IW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);
	localparam int PW = $clog2(MAX_LEN * MAX_LEN);

	localparam logic CFG_OPEN   = 1'b0;
	localparam logic CFG_EXTEND = 1'b1;

	// memories
	logic [7:0]  s_mem [MAX_LEN];
	logic [7:0]  t_mem [MAX_LEN];
	score_t      score_mem [MAX_LEN + 1];
	score_t      vgap_mem [MAX_LEN + 1];
	logic [1:0]  ptr_mem [MAX_LEN * MAX_LEN];

	logic [7:0]  s_rd_q, t_rd_q;
	score_t      score_rd_q, vgap_rd_q;
	logic [1:0]  ptr_rd_q;

	state_t      state_q, state_d;

	logic [7:0]  gap_open_q, gap_ext_q;
	logic [IW-1:0] s_len_q, t_len_q;
	logic        s_closed_q, t_closed_q, s_over_q, t_over_q;
	logic [IW-1:0] trace_row_q, trace_col_q;
	logic        trace_active_q;
	logic [PW-1:0] trace_addr_q;

	// fill datapath
	logic [IW-1:0] row_q, col_q;
	logic [PW-1:0] pa_q, rowbase_q;
	score_t      run_q, lb_q, rowdiag_q, diag_q, left_q, e_q, final_q;

	// output register
	logic        out_valid_q;
	status_t     out_status_q;
	logic signed [OUT_W-1:0] out_score_q;
	logic [7:0]  out_s_char_q, out_t_char_q;
	logic        out_s_gap_q, out_t_gap_q, out_last_q;

	score_t      go_s, ge_s, lb_next, cell_v, cell_f, cell_e;
	logic [1:0]  cell_p;
	opcode_t     op;
	logic        accept, is_load, fits, load_last_t, dropped;
	logic        take_s, take_t, no_column;
	logic [IW-1:0] eff_len, s_ridx, t_ridx;

	assign go_s    = score_t'({1'b0, gap_open_q});
	assign ge_s    = score_t'({1'b0, gap_ext_q});
	assign lb_next = lb_q - ge_s;
	assign op      = opcode_t'(s_tuser);
	assign accept  = s_tvalid && s_tready;
	assign is_load = (op == OP_LOAD_S) || (op == OP_LOAD_T);

	// effective length after a possible restart of the sequence
	always_comb begin
		if (op == OP_LOAD_S)
			eff_len = s_closed_q ? '0 : s_len_q;
		else
			eff_len = t_closed_q ? '0 : t_len_q;
	end
	assign fits        = eff_len < IW'(MAX_LEN);
	assign dropped     = !fits;
	assign load_last_t = (op == OP_LOAD_T) && s_tlast;

	// traceback decision from registered reads
	assign no_column = !trace_active_q || (trace_row_q == '0 && trace_col_q == '0);
	always_comb begin
		if (trace_row_q == '0) begin
			take_s = 1'b0;
			take_t = 1'b1;
		end else if (trace_col_q == '0) begin
			take_s = 1'b1;
			take_t = 1'b0;
		end else begin
			take_s = ptr_rd_q != PTR_LEFT;
			take_t = ptr_rd_q != PTR_UP;
		end
	end

	// read addresses: traceback in idle, fill counters otherwise
	assign s_ridx = (state_q == ST_IDLE) ? trace_row_q - 1'b1 : row_q - 1'b1;
	assign t_ridx = (state_q == ST_IDLE) ? trace_col_q - 1'b1 : col_q - 1'b1;

	always_ff @(posedge clk) begin
		if (accept && op == OP_LOAD_S && fits)
			s_mem[eff_len[AW-1:0]] <= s_tdata;
		s_rd_q <= s_mem[s_ridx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept && op == OP_LOAD_T && fits)
			t_mem[eff_len[AW-1:0]] <= s_tdata;
		t_rd_q <= t_mem[t_ridx[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			score_mem[col_q] <= run_q;
			vgap_mem[col_q]  <= NEG_INF;
		end else if (state_q == ST_CEX) begin
			score_mem[col_q] <= cell_v;
			vgap_mem[col_q]  <= cell_f;
		end
		score_rd_q <= score_mem[col_q];
		vgap_rd_q  <= vgap_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CEX)
			ptr_mem[pa_q] <= cell_p;
		ptr_rd_q <= ptr_mem[trace_addr_q];
	end

	agga_cell u_cell (
		.diag   (diag_q),
		.up     (score_rd_q),
		.vgap   (vgap_rd_q),
		.left   (left_q),
		.e_prev (e_q),
		.go     (go_s),
		.ge     (ge_s),
		.s_char (s_rd_q),
		.t_char (t_rd_q),
		.v      (cell_v),
		.f      (cell_f),
		.e      (cell_e),
		.ptr    (cell_p)
	);

	// next state and ready
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				if (accept) begin
					if (op == OP_FETCH)
						state_d = ST_FEX;
					else if (load_last_t && !s_over_q && !dropped)
						state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (col_q == t_len_q)
					state_d = (s_len_q == '0) ? ST_DONE : ST_CRD;
			end
			ST_CRD: state_d = ST_CEX;
			ST_CEX: begin
				if (col_q == t_len_q && row_q == s_len_q)
					state_d = ST_DONE;
				else
					state_d = ST_CRD;
			end
			ST_DONE: state_d = ST_IDLE;
			ST_FEX:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			gap_open_q     <= 8'd16;
			gap_ext_q      <= 8'd4;
			s_len_q        <= '0;
			t_len_q        <= '0;
			s_closed_q     <= 1'b1;
			t_closed_q     <= 1'b1;
			s_over_q       <= 1'b0;
			t_over_q       <= 1'b0;
			trace_row_q    <= '0;
			trace_col_q    <= '0;
			trace_active_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_OPEN:   gap_open_q <= cfg_data;
					CFG_EXTEND: gap_ext_q  <= cfg_data;
					default:    ;
				endcase
			end
			// drop the result once taken; producers below override
			if (m_tready)
				out_valid_q <= 1'b0;
			if (state_q == ST_IDLE && accept && is_load) begin
				trace_active_q <= 1'b0;
				if (op == OP_LOAD_S) begin
					s_len_q    <= fits ? eff_len + 1'b1 : eff_len;
					s_over_q   <= (s_closed_q ? 1'b0 : s_over_q) || dropped;
					s_closed_q <= s_tlast;
				end else begin
					t_len_q    <= fits ? eff_len + 1'b1 : eff_len;
					t_over_q   <= (t_closed_q ? 1'b0 : t_over_q) || dropped;
					t_closed_q <= s_tlast;
				end
				if (dropped || (load_last_t && s_over_q) ||
				    (load_last_t && !t_closed_q && t_over_q))
					out_valid_q <= 1'b1;
			end
			if (state_q == ST_DONE) begin
				out_valid_q    <= 1'b1;
				trace_row_q    <= s_len_q;
				trace_col_q    <= t_len_q;
				trace_active_q <= 1'b1;
			end
			if (state_q == ST_FEX) begin
				out_valid_q <= 1'b1;
				if (!no_column) begin
					if (take_s)
						trace_row_q <= trace_row_q - 1'b1;
					if (take_t)
						trace_col_q <= trace_col_q - 1'b1;
				end
			end
		end
	end

	// fill datapath and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				// clear the payload only as a request enters; a waiting result holds
				if (accept) begin
					out_status_q <= STAT_OVER;
					out_score_q  <= '0;
					out_s_char_q <= '0;
					out_t_char_q <= '0;
					out_s_gap_q  <= 1'b0;
					out_t_gap_q  <= 1'b0;
					out_last_q   <= 1'b0;
				end
				col_q        <= IW'(1);
				row_q        <= IW'(1);
				run_q        <= -go_s - ge_s;
				lb_q         <= -go_s;
				rowdiag_q    <= '0;
				pa_q         <= '0;
				rowbase_q    <= '0;
			end
			ST_INIT: begin
				run_q <= run_q - ge_s;
				if (col_q == t_len_q) begin
					final_q   <= run_q;
					col_q     <= IW'(1);
					// open row 1
					lb_q      <= lb_next;
					left_q    <= lb_next;
					diag_q    <= rowdiag_q;
					rowdiag_q <= lb_next;
					e_q       <= NEG_INF;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			ST_CRD: ;
			ST_CEX: begin
				if (col_q == t_len_q) begin
					final_q <= cell_v;
					if (row_q == s_len_q) begin
						trace_addr_q <= pa_q;
					end else begin
						// advance to the next row
						row_q     <= row_q + 1'b1;
						col_q     <= IW'(1);
						rowbase_q <= rowbase_q + PW'(MAX_LEN);
						pa_q      <= rowbase_q + PW'(MAX_LEN);
						lb_q      <= lb_next;
						left_q    <= lb_next;
						diag_q    <= rowdiag_q;
						rowdiag_q <= lb_next;
						e_q       <= NEG_INF;
					end
				end else begin
					col_q  <= col_q + 1'b1;
					pa_q   <= pa_q + 1'b1;
					diag_q <= score_rd_q;
					left_q <= cell_v;
					e_q    <= cell_e;
				end
			end
			ST_DONE: begin
				out_status_q <= STAT_SCORE;
				out_score_q  <= saturate(final_q);
			end
			ST_FEX: begin
				if (no_column) begin
					out_status_q <= STAT_NONE;
				end else begin
					out_status_q <= STAT_COLUMN;
					out_s_char_q <= take_s ? s_rd_q : 8'd0;
					out_s_gap_q  <= !take_s;
					out_t_char_q <= take_t ? t_rd_q : 8'd0;
					out_t_gap_q  <= !take_t;
					out_last_q   <= (trace_row_q - IW'(take_s)) == '0 &&
					                (trace_col_q - IW'(take_t)) == '0;
					// step the pointer address only inside the table
					if (trace_row_q != '0 && trace_col_q != '0)
						trace_addr_q <= trace_addr_q - (take_s ? PW'(MAX_LEN) : '0)
						                - PW'(take_t);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0, out_t_gap_q, out_t_char_q, out_s_gap_q, out_s_char_q,
	                   out_score_q};
	assign m_tlast  = out_last_q;

	`include "affine_gap_global_alignment_defines.svh"

	`AGGA_ASSERT_IMP(a_trace_in_range, trace_active_q, (trace_row_q <= s_len_q) && (trace_col_q <= t_len_q))
	`AGGA_ASSERT_IMP(a_column_not_double_gap, m_tvalid && (m_tuser == STAT_COLUMN), !(m_tdata[26] && m_tdata[35]))
	`AGGA_ASSERT_NXT(a_cell_loop, state_q == ST_CEX, (state_q == ST_CRD) || (state_q == ST_DONE))

endmodule

FILE: tb/sv/affine_gap_global_alignment_tb.sv
module affine_gap_global_alignment_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import agga_pkg::*;

	localparam int SEQ_MAX    = 256;
	localparam int MINUS_INF  = -(1 << 28);
	localparam int SAT_HI     = 131071;
	localparam int SAT_LO     = -131072;
	localparam int STALL_LIMIT = 600000;  // longest fill covers a 256x256 table plus init
	localparam int SETTLE     = 8;        // wait for the last request to leave the pipe
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 600;

	// One column, score or status word as it leaves the block.
	typedef struct packed {
		status_t            status;
		logic signed [17:0] score;
		logic [7:0]         s_char;
		logic               s_gap;
		logic [7:0]         t_char;
		logic               t_gap;
		logic               last_col;
	} align_word_t;

	// Directed request; typed rows carry their own status and score.
	typedef struct {
		opcode_t            op;
		logic [7:0]         sym;
		logic               last;
		bit                 typed;
		status_t            t_status;
		int                 t_score;
	} req_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	affine_gap_global_alignment u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the aligner state.
	int          pen_open = 16;
	int          pen_ext = 4;
	logic [7:0]  seq_s [SEQ_MAX];
	logic [7:0]  seq_t [SEQ_MAX];
	int          len_s, len_t;
	bit          closed_s = 1, closed_t = 1, over_s, over_t;
	logic [1:0]  trace_ptr [SEQ_MAX*SEQ_MAX];
	int          row_v [SEQ_MAX+1];
	int          row_f [SEQ_MAX+1];
	int          tr_row, tr_col;
	bit          tr_live;

	align_word_t pending_words [$];
	int          errors, words_seen, reqs_sent, fills_seen, columns_seen;
	int          tx_idle_pct, rx_idle_pct;
	int          hold_req_cnt, hold_seen_cnt, hold_left;
	int          quiet_cycles;

	function automatic logic [7:0] fold_case(logic [7:0] c);
		if (c inside {[8'h61:8'h7a]})
			return c & 8'hdf;
		return c;
	endfunction

	function automatic int pair_score(logic [7:0] a, logic [7:0] b);
		if (fold_case(a) != fold_case(b))
			return -1;
		return (a == 8'h2d) ? 0 : 1;
	endfunction

	// Fill the pointer table row by row and return V at full lengths.
	function automatic int fill_score();
		int diag, left, e, f, g, v, up;
		row_v[0] = 0;
		row_f[0] = MINUS_INF;
		for (int j = 1; j <= len_t; j++) begin
			row_v[j] = -pen_open - j * pen_ext;
			row_f[j] = MINUS_INF;
		end
		for (int i = 1; i <= len_s; i++) begin
			diag = row_v[0];
			left = -pen_open - i * pen_ext;
			e = MINUS_INF;
			row_v[0] = left;
			for (int j = 1; j <= len_t; j++) begin
				up = row_v[j];
				g = diag + pair_score(seq_s[i-1], seq_t[j-1]);
				f = (row_f[j] - pen_ext > up - pen_open - pen_ext) ?
					row_f[j] - pen_ext : up - pen_open - pen_ext;
				e = (e - pen_ext > left - pen_open - pen_ext) ?
					e - pen_ext : left - pen_open - pen_ext;
				v = g;
				if (f > v) v = f;
				if (e > v) v = e;
				trace_ptr[(i-1)*SEQ_MAX + (j-1)] =
					(v == g) ? PTR_DIAG : (v == e) ? PTR_LEFT : PTR_UP;
				row_f[j] = f;
				row_v[j] = v;
				diag = up;
				left = v;
			end
		end
		return row_v[len_t];
	endfunction

	// Advance the shadow state by one accepted request; has is set when a word follows.
	task automatic predict_word(opcode_t op, logic [7:0] sym, logic last,
	                            output bit has, output align_word_t w);
		bit dropped, take_s, take_t;
		int v;
		logic [1:0] p;
		w = '0;
		has = 0;
		dropped = 0;
		if (op == OP_LOAD_S || op == OP_LOAD_T) begin
			tr_live = 0;
			if (op == OP_LOAD_S) begin
				if (closed_s) begin len_s = 0; over_s = 0; closed_s = 0; end
				if (len_s < SEQ_MAX) begin seq_s[len_s] = sym; len_s++; end
				else begin over_s = 1; dropped = 1; end
				if (last) closed_s = 1;
			end else begin
				if (closed_t) begin len_t = 0; over_t = 0; closed_t = 0; end
				if (len_t < SEQ_MAX) begin seq_t[len_t] = sym; len_t++; end
				else begin over_t = 1; dropped = 1; end
				if (last) closed_t = 1;
			end
			if (op == OP_LOAD_T && last) begin
				has = 1;
				if (over_s || over_t) begin
					w.status = STAT_OVER;
				end else begin
					v = fill_score();
					if (v > SAT_HI) v = SAT_HI;
					if (v < SAT_LO) v = SAT_LO;
					tr_row = len_s;
					tr_col = len_t;
					tr_live = 1;
					w.status = STAT_SCORE;
					w.score = v[17:0];
				end
			end else if (dropped) begin
				has = 1;
				w.status = STAT_OVER;
			end
		end else if (op == OP_FETCH) begin
			has = 1;
			if (!tr_live || (tr_row == 0 && tr_col == 0)) begin
				w.status = STAT_NONE;
			end else begin
				// Past the border only one sequence has characters left.
				if (tr_row == 0) begin
					take_s = 0; take_t = 1;
				end else if (tr_col == 0) begin
					take_s = 1; take_t = 0;
				end else begin
					p = trace_ptr[(tr_row-1)*SEQ_MAX + (tr_col-1)];
					take_s = (p != PTR_LEFT);
					take_t = (p != PTR_UP);
				end
				w.status = STAT_COLUMN;
				if (take_s) begin w.s_char = seq_s[tr_row-1]; tr_row--; end
				else w.s_gap = 1;
				if (take_t) begin w.t_char = seq_t[tr_col-1]; tr_col--; end
				else w.t_gap = 1;
				w.last_col = (tr_row == 0 && tr_col == 0);
			end
		end
	endtask

	task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
		errors++;
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	// Offer one request, hold it until taken, then predict its word.
	task automatic send_req(opcode_t op, logic [7:0] sym, logic last,
	                        bit typed = 0, status_t t_status = STAT_SCORE, int t_score = 0);
		bit has;
		align_word_t w;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= sym;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		reqs_sent++;
		predict_word(op, sym, last, has, w);
		if (typed) begin
			w = '0;
			w.status = t_status;
			w.score = t_score[17:0];
		end
		if (has) pending_words.push_back(w);
	endtask

	// Pause the sender until every expected word has come, then let the pipe settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_penalty(logic idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == 1'b0) pen_open = int'(val);
		else pen_ext = int'(val);
	endtask

	function automatic logic [7:0] pick_char();
		string bases = "ACGTacgt-";
		if ($urandom_range(9) < 7)
			return bases[$urandom_range(8)];
		return 8'($urandom_range(255));
	endfunction

	// A well-formed job: load S, load T, then send the given number of fetches.
	task automatic run_job(int ls, int lt, int fetches);
		for (int k = 0; k < ls; k++) send_req(OP_LOAD_S, pick_char(), k == ls - 1);
		for (int k = 0; k < lt; k++) send_req(OP_LOAD_T, pick_char(), k == lt - 1);
		for (int k = 0; k < fetches; k++)
			send_req(OP_FETCH, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic send_noise();
		send_req(opcode_t'($urandom_range(3)), 8'($urandom_range(255)),
		         1'($urandom_range(1)));
	endtask

	task automatic random_phase(int items);
		int stop, ls, lt;
		stop = reqs_sent + items;
		while (reqs_sent < stop) begin
			ls = $urandom_range(12, 1);
			lt = $urandom_range(12, 1);
			case ($urandom_range(19))
				0: begin  // broken job: stray loads and fetches
					repeat ($urandom_range(6, 1)) send_noise();
				end
				1: begin  // fetch cut short, then a load clears the traceback
					run_job(ls, lt, $urandom_range(ls + lt));
					send_req(OP_LOAD_S, pick_char(), 1'b0);
					send_req(OP_FETCH, 8'h00, 1'b0);
				end
				default: run_job(ls, lt, ls + lt + $urandom_range(1));
			endcase
			if ($urandom_range(9) == 0) send_noise();
		end
	endtask

	// Receiver: check each taken word against the oldest expectation, then pick ready.
	always @(posedge clk) begin
		align_word_t want, got;
		if (m_tvalid && m_tready) begin
			words_seen++;
			got = '0;
			got.status = status_t'(m_tuser);
			got.score = m_tdata[17:0];
			got.s_char = m_tdata[25:18];
			got.s_gap = m_tdata[26];
			got.t_char = m_tdata[34:27];
			got.t_gap = m_tdata[35];
			got.last_col = m_tlast;
			if (got.status == STAT_SCORE) fills_seen++;
			if (got.status == STAT_COLUMN) columns_seen++;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", {m_tuser, m_tlast, m_tdata[36:0]}, '0);
			end else begin
				want = pending_words.pop_front();
				if (got.status != want.status)
					report_mismatch("status", 40'(got.status), 40'(want.status));
				if (got.score != want.score)
					report_mismatch("score", 40'(got.score), 40'(want.score));
				if (got.s_char != want.s_char)
					report_mismatch("s char", 40'(got.s_char), 40'(want.s_char));
				if (got.s_gap != want.s_gap)
					report_mismatch("s gap", 40'(got.s_gap), 40'(want.s_gap));
				if (got.t_char != want.t_char)
					report_mismatch("t char", 40'(got.t_char), 40'(want.t_char));
				if (got.t_gap != want.t_gap)
					report_mismatch("t gap", 40'(got.t_gap), 40'(want.t_gap));
				if (got.last_col != want.last_col)
					report_mismatch("last column", 40'(got.last_col), 40'(want.last_col));
			end
		end
		if (hold_seen_cnt != hold_req_cnt) begin
			hold_seen_cnt = hold_req_cnt;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d words outstanding", pending_words.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	req_row_t directed [] = '{
		'{OP_FETCH,  8'h00, 1'b0, 1, STAT_NONE,  0},   // nothing to fetch after reset
		'{OP_NONE,   8'hff, 1'b1, 0, STAT_SCORE, 0},   // unused opcode, dropped
		'{OP_LOAD_T, 8'h78, 1'b0, 0, STAT_SCORE, 0},
		'{OP_LOAD_T, 8'h79, 1'b1, 1, STAT_SCORE, -24}, // empty S: -open - 2*extend
		'{OP_FETCH,  8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_FETCH,  8'hff, 1'b1, 0, STAT_SCORE, 0},
		'{OP_FETCH,  8'h00, 1'b0, 1, STAT_NONE,  0},   // past the start column
		'{OP_LOAD_S, 8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_LOAD_S, 8'hff, 1'b1, 0, STAT_SCORE, 0},
		'{OP_LOAD_T, 8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_LOAD_T, 8'hff, 1'b1, 1, STAT_SCORE, 2},   // two straight matches
		'{OP_FETCH,  8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_FETCH,  8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_LOAD_S, 8'h2d, 1'b1, 0, STAT_SCORE, 0},
		'{OP_LOAD_T, 8'h2d, 1'b1, 1, STAT_SCORE, 0},   // dash against dash scores zero
		'{OP_FETCH,  8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_LOAD_S, 8'h7a, 1'b1, 0, STAT_SCORE, 0},
		'{OP_LOAD_T, 8'h5a, 1'b0, 0, STAT_SCORE, 0},   // case folded match
		'{OP_LOAD_T, 8'h71, 1'b1, 0, STAT_SCORE, 0},
		'{OP_FETCH,  8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_FETCH,  8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_FETCH,  8'h00, 1'b0, 0, STAT_SCORE, 0},
		'{OP_LOAD_S, 8'h61, 1'b0, 0, STAT_SCORE, 0},
		'{OP_FETCH,  8'h00, 1'b0, 1, STAT_NONE,  0},   // a load kills the traceback
		'{OP_LOAD_S, 8'h62, 1'b1, 0, STAT_SCORE, 0}
	};

	initial begin
		tx_idle_pct = 12;
		rx_idle_pct = 84;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[n])
			send_req(directed[n].op, directed[n].sym, directed[n].last, directed[n].typed,
			         directed[n].t_status, directed[n].t_score);
		wait_drained();

		// Phase one: eager sender, slow receiver, zero penalties.
		write_penalty(1'b0, 8'd0);
		write_penalty(1'b1, 8'd0);
		random_phase(RANDOM_ITEMS / 3);

		// Fill the output side while the receiver holds off.
		hold_req_cnt <= hold_req_cnt + 1;
		run_job(3, 3, 12);
		repeat (10) send_req(OP_FETCH, 8'h00, 1'b0);
		wait_drained();

		// Overflow: S two too long, then T one too long.
		run_job(SEQ_MAX + 2, 2, 2);
		run_job(2, SEQ_MAX + 1, 1);
		wait_drained();

		// Phase two: roles swapped, maximum penalties.
		tx_idle_pct = 84;
		rx_idle_pct = 12;
		write_penalty(1'b0, 8'd255);
		write_penalty(1'b1, 8'd255);
		random_phase(RANDOM_ITEMS / 3);
		wait_drained();

		// Phase three: no idling, random penalties, then one full-size job.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_penalty(1'b0, 8'($urandom_range(255)));
		write_penalty(1'b1, 8'($urandom_range(8)));
		random_phase(RANDOM_ITEMS / 3);
		wait_drained();
		write_penalty(1'b0, 8'd16);
		write_penalty(1'b1, 8'd4);
		run_job(SEQ_MAX, SEQ_MAX, 40);
		wait_drained();

		$display("sent %0d requests, checked %0d words: %0d scores, %0d columns",
		         reqs_sent, words_seen, fills_seen, columns_seen);
		$display("covered empty S, overflow, full-size tables, both penalty extremes");
		if (errors == 0 && pending_words.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d words never came", errors, pending_words.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/agga_pkg.sv
rtl/agga_cell.sv
rtl/affine_gap_global_alignment.sv
tb/sv/affine_gap_global_alignment_tb.sv
